[hw/rtl/mscc_pkg.sv]
package mscc_pkg;

  // Start code prefix and stream id values
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_ONE    = 8'h01;
  localparam logic [7:0] ID_SEQ_HDR  = 8'hB3;
  localparam logic [7:0] ID_GOP      = 8'hB8;
  localparam logic [7:0] ID_PACK     = 8'hBA;
  localparam logic [7:0] ID_PICTURE  = 8'h00;
  localparam logic [7:0] ID_SLICE_LO = 8'h01;
  localparam logic [7:0] ID_SLICE_HI = 8'hAF;
  localparam logic [7:0] ID_AUDIO_LO = 8'hC0;
  localparam logic [7:0] ID_AUDIO_HI = 8'hDF;
  localparam logic [7:0] ID_VIDEO_LO = 8'hE0;
  localparam logic [7:0] ID_VIDEO_HI = 8'hEF;

  localparam logic [3:0] RATE_MIN  = 4'd1;
  localparam logic [3:0] RATE_MAX  = 4'd8;
  localparam logic [2:0] CTYPE_MIN = 3'd1;
  localparam logic [2:0] CTYPE_MAX = 3'd3;

  typedef enum logic [2:0] {
    KIND_SEQ_HDR = 3'd0,
    KIND_GOP     = 3'd1,
    KIND_PACK    = 3'd2,
    KIND_PICTURE = 3'd3,
    KIND_SLICE   = 3'd4,
    KIND_AUDIO   = 3'd5,
    KIND_VIDEO   = 3'd6,
    KIND_OTHER   = 3'd7
  } kind_t;

  typedef enum logic [7:0] {
    PH_SCAN = 8'b0000_0001,
    PH_ID   = 8'b0000_0010,
    PH_SEQ1 = 8'b0000_0100,
    PH_SEQ2 = 8'b0000_1000,
    PH_SEQ3 = 8'b0001_0000,
    PH_SEQ4 = 8'b0010_0000,
    PH_PIC1 = 8'b0100_0000,
    PH_PIC2 = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    kind_t       unit_kind;
    logic [7:0]  stream_id;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [3:0]  rate_code;
    logic [2:0]  coding_type;
  } result_t;

endpackage

[hw/rtl/mpeg_start_code_classifier.sv]
// MPEG-1 program stream start code classifier. Stream bytes enter one beat per
// clock on in_data_byte while in_stall is low; the block finds 00 00 01
// prefixes (any run of two or more zeros before 0x01), classifies the next
// byte as the stream id and reports one beat per unit. Sequence headers
// (0xB3) report after four more bytes with width, height and frame-rate
// code (codes 1..8 only, else nothing); picture headers (0x00) report after
// two more bytes with the coding type (I/P/B only). Audio packets are
// 0xC0-0xDF, video packets 0xE0-0xEF. Fields that do not apply to a unit are
// zero. Id and header bytes are never searched for a prefix. Throughput is
// one byte per clock while the output queue has room: the input register
// feeds the parser, whose next state is combinational, and results are
// registered in a two-entry output queue. in_stall rises only while the
// output queue is full and the input register holds a byte.
module mpeg_start_code_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_unit_kind,
  output logic [7:0]  out_stream_id,
  output logic [11:0] out_frame_width,
  output logic [11:0] out_frame_height,
  output logic [3:0]  out_rate_code,
  output logic [2:0]  out_coding_type
);
  import mscc_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       q_space;
  logic       take;
  logic       res_vld;
  result_t    res;
  result_t    out_res;

  // byte in the input register is parsed once the queue has room
  assign take     = in_vld_r && q_space;
  assign in_stall = in_vld_r && !q_space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte_r <= in_data_byte;
  end

  mscc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_byte_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  mscc_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && res_vld),
    .push_data (res),
    .space     (q_space),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_unit_kind    = out_res.unit_kind;
  assign out_stream_id    = out_res.stream_id;
  assign out_frame_width  = out_res.frame_width;
  assign out_frame_height = out_res.frame_height;
  assign out_rate_code    = out_res.rate_code;
  assign out_coding_type  = out_res.coding_type;

endmodule

[hw/rtl/mscc_core.sv]
module mscc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       data_byte,
  output logic             res_vld,
  output mscc_pkg::result_t res
);
  import mscc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  zero_run_r, zero_run_nxt;
  logic [23:0] held_r, held_nxt;
  logic [3:0]  rate;
  logic [2:0]  ctype;

  assign rate  = data_byte[3:0];
  assign ctype = data_byte[5:3];

  always_comb begin
    phase_nxt    = phase_r;
    zero_run_nxt = zero_run_r;
    held_nxt     = held_r;
    res_vld      = 1'b0;
    res          = '0;
    res.stream_id = data_byte;
    case (phase_r)
      PH_SCAN: begin
        if (data_byte == BYTE_ZERO) begin
          if (zero_run_r != 2'd2) zero_run_nxt = zero_run_r + 2'd1;
        end else if (data_byte == BYTE_ONE && zero_run_r == 2'd2) begin
          zero_run_nxt = 2'd0;
          phase_nxt    = PH_ID;
        end else begin
          zero_run_nxt = 2'd0;
        end
      end
      PH_ID: begin
        zero_run_nxt = 2'd0;
        held_nxt     = '0;
        if (data_byte == ID_SEQ_HDR) begin
          phase_nxt = PH_SEQ1;
        end else if (data_byte == ID_PICTURE) begin
          phase_nxt = PH_PIC1;
        end else begin
          phase_nxt = PH_SCAN;
          res_vld   = 1'b1;
          if (data_byte == ID_GOP) begin
            res.unit_kind = KIND_GOP;
          end else if (data_byte == ID_PACK) begin
            res.unit_kind = KIND_PACK;
          end else if (data_byte >= ID_SLICE_LO && data_byte <= ID_SLICE_HI) begin
            res.unit_kind = KIND_SLICE;
          end else if (data_byte >= ID_AUDIO_LO && data_byte <= ID_AUDIO_HI) begin
            res.unit_kind = KIND_AUDIO;
          end else if (data_byte >= ID_VIDEO_LO && data_byte <= ID_VIDEO_HI) begin
            res.unit_kind = KIND_VIDEO;
          end else begin
            res.unit_kind = KIND_OTHER;
          end
        end
      end
      PH_SEQ1, PH_SEQ2, PH_SEQ3, PH_PIC1: begin
        held_nxt = {held_r[15:0], data_byte};
        case (phase_r)
          PH_SEQ1: phase_nxt = PH_SEQ2;
          PH_SEQ2: phase_nxt = PH_SEQ3;
          PH_SEQ3: phase_nxt = PH_SEQ4;
          default: phase_nxt = PH_PIC2;
        endcase
      end
      PH_SEQ4: begin
        phase_nxt    = PH_SCAN;
        zero_run_nxt = 2'd0;
        held_nxt     = '0;
        if (rate >= RATE_MIN && rate <= RATE_MAX) begin
          res_vld          = 1'b1;
          res.unit_kind    = KIND_SEQ_HDR;
          res.stream_id    = ID_SEQ_HDR;
          res.frame_width  = {held_r[23:16], held_r[15:12]};
          res.frame_height = {held_r[11:8], held_r[7:0]};
          res.rate_code    = rate;
        end
      end
      PH_PIC2: begin
        phase_nxt    = PH_SCAN;
        zero_run_nxt = 2'd0;
        held_nxt     = '0;
        if (ctype >= CTYPE_MIN && ctype <= CTYPE_MAX) begin
          res_vld         = 1'b1;
          res.unit_kind   = KIND_PICTURE;
          res.stream_id   = ID_PICTURE;
          res.coding_type = ctype;
        end
      end
      default: begin
        phase_nxt    = PH_SCAN;
        zero_run_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SCAN;
      zero_run_r <= 2'd0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      zero_run_r <= zero_run_nxt;
    end
  end

  // held bytes are cleared on every id byte before use
  always_ff @(posedge clk) begin
    if (take) held_r <= held_nxt;
  end

`ifndef NO_ASSERTIONS
  // a unit report always ends the unit and returns to prefix search
  a_res_ends_unit: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_vld |=> phase_r == PH_SCAN)
    else $error("result without return to scan");

  // prefix counter only runs while scanning
  a_zero_run_scan: assert property (@(posedge clk) disable iff (!rst_n)
    zero_run_r != 2'd0 |-> phase_r == PH_SCAN)
    else $error("zero run outside scan phase");
`endif

endmodule

[hw/rtl/mscc_out_q.sv]
module mscc_out_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mscc_pkg::result_t push_data,
  output logic              space,
  output logic              out_vld,
  input  logic              out_stall,
  output mscc_pkg::result_t out_data
);
  import mscc_pkg::*;

  result_t    ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_vld  = cnt_r != 2'd0;
  assign out_data = ent_r[rd_ptr_r];
  assign pop      = out_vld && !out_stall;
  assign space    = cnt_r != 2'd2;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_data;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("result queue overflow");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");
`endif

endmodule
